### rtl/sorted_insert_priority_queue_top_macros.svh
// assertion helpers used by the checker file
// all assertions sample on clk and are disabled while rst_n is low
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define SIPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define SIPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/sipq_pkg.sv
`timescale 1ns / 1ps

package sipq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TIME_W = 16;
    localparam int INFO_W = 8;
    localparam int ENTRY_W = TIME_W + INFO_W;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] time_key;
        logic [INFO_W-1:0] info;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ_START,
        ST_ENQ_CMP,
        ST_DEQ_WAIT,
        ST_FIN
    } state_t;

endpackage

### rtl/sipq_ram.sv
`timescale 1ns / 1ps

module sipq_ram #(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  sipq_pkg::entry_t       wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output sipq_pkg::entry_t       rd_data
);

    sipq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/sorted_insert_priority_queue_top.sv
`timescale 1ns / 1ps

// Priority queue of (time, info) entries held sorted by time in a circular buffer of
// DEPTH slots; equal times leave in arrival order. One command is taken at a time and
// in_stall stays high until its result has been moved into the output register. A
// rejected command goes straight to the final step, a dequeue first reads the head entry,
// an enqueue into an empty queue writes its entry at once, and any other enqueue walks
// toward the head past every stored entry with a larger time. The next command can be
// taken in the cycle after the result is loaded. Each step of the insertion walk is one
// memory read, one time compare and one memory write in the entry store.
// A waiting result stalls the final step until res_stall drops.
module sorted_insert_priority_queue_top #(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [sipq_pkg::TIME_W-1:0]        item_time,
    input  logic [sipq_pkg::INFO_W-1:0]        item_info,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic                               out_valid,
    output logic [sipq_pkg::TIME_W-1:0]        out_time,
    output logic [sipq_pkg::INFO_W-1:0]        out_info,
    output logic [sipq_pkg::STATUS_W-1:0]      status,
    output logic [sipq_pkg::OCC_W-1:0]         occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        slot_next = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        slot_prev = (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    sipq_pkg::state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    sipq_pkg::entry_t new_reg, new_next;
    sipq_pkg::entry_t r_entry_reg, r_entry_next;
    logic r_valid_reg, r_valid_next;
    logic [sipq_pkg::STATUS_W-1:0] r_status_reg, r_status_next;

    logic res_valid_reg, res_valid_next;
    logic out_valid_reg, out_valid_next;
    sipq_pkg::entry_t out_entry_reg, out_entry_next;
    logic [sipq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [sipq_pkg::OCC_W-1:0] occ_reg, occ_next;

    logic accept;
    logic is_full;
    logic is_empty;
    logic out_free;
    logic less;
    logic [AW-1:0] pos_prev;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    sipq_pkg::entry_t wr_data;
    logic rd_en;
    logic [AW-1:0] rd_addr;
    sipq_pkg::entry_t rd_data;

    sipq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign accept = in_valid && !in_stall;
    assign is_full = (count_reg >= CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign out_free = !res_valid_reg || !res_stall;
    assign pos_prev = slot_prev(pos_reg);
    // shared compare: new entry passes a neighbor only on a strictly larger time
    assign less = (new_reg.time_key < rd_data.time_key);

    assign in_stall = (state_reg != sipq_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_time = out_entry_reg.time_key;
    assign out_info = out_entry_reg.info;
    assign status = status_reg;
    assign occupancy = occ_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sipq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == sipq_pkg::CMD_ENQ)
                    begin
                        state_next = is_full ? sipq_pkg::ST_FIN : sipq_pkg::ST_ENQ_START;
                    end
                    else
                    begin
                        state_next = is_empty ? sipq_pkg::ST_FIN : sipq_pkg::ST_DEQ_WAIT;
                    end
                end
            end
            sipq_pkg::ST_ENQ_START:
            begin
                state_next = (pos_reg == head_reg) ? sipq_pkg::ST_FIN : sipq_pkg::ST_ENQ_CMP;
            end
            sipq_pkg::ST_ENQ_CMP:
            begin
                if (!less)
                begin
                    state_next = sipq_pkg::ST_FIN;
                end
                else if (pos_prev == head_reg)
                begin
                    state_next = sipq_pkg::ST_ENQ_START;
                end
            end
            sipq_pkg::ST_DEQ_WAIT:
            begin
                state_next = sipq_pkg::ST_FIN;
            end
            sipq_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = sipq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sipq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        new_next = new_reg;
        r_entry_next = r_entry_reg;
        r_valid_next = r_valid_reg;
        r_status_next = r_status_reg;
        res_valid_next = res_valid_reg && res_stall;
        out_valid_next = out_valid_reg;
        out_entry_next = out_entry_reg;
        status_next = status_reg;
        occ_next = occ_reg;
        wr_en = 1'b0;
        wr_addr = pos_reg;
        wr_data = new_reg;
        rd_en = 1'b0;
        rd_addr = pos_prev;

        case (state_reg)
            sipq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    new_next = '{time_key: item_time, info: item_info};
                    pos_next = tail_reg;
                    r_valid_next = 1'b0;
                    r_entry_next = '0;
                    r_status_next = sipq_pkg::STATUS_OK;
                    if (cmd == sipq_pkg::CMD_ENQ)
                    begin
                        if (is_full)
                        begin
                            r_status_next = sipq_pkg::STATUS_FULL;
                        end
                    end
                    else if (is_empty)
                    begin
                        r_status_next = sipq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        rd_addr = head_reg;
                    end
                end
            end
            sipq_pkg::ST_ENQ_START:
            begin
                if (pos_reg == head_reg)
                begin
                    wr_en = 1'b1;
                    tail_next = slot_next(tail_reg);
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            sipq_pkg::ST_ENQ_CMP:
            begin
                wr_en = 1'b1;
                if (less)
                begin
                    // move the larger neighbor up one slot and keep walking
                    wr_data = rd_data;
                    pos_next = pos_prev;
                    if (pos_prev != head_reg)
                    begin
                        rd_en = 1'b1;
                        rd_addr = slot_prev(pos_prev);
                    end
                end
                else
                begin
                    tail_next = slot_next(tail_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            sipq_pkg::ST_DEQ_WAIT:
            begin
                r_valid_next = 1'b1;
                r_entry_next = rd_data;
                head_next = slot_next(head_reg);
                count_next = count_reg - CW'(1);
            end
            sipq_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    out_valid_next = r_valid_reg;
                    out_entry_next = r_entry_reg;
                    status_next = r_status_reg;
                    occ_next = sipq_pkg::OCC_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sipq_pkg::ST_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        new_reg <= new_next;
        r_entry_reg <= r_entry_next;
        r_valid_reg <= r_valid_next;
        r_status_reg <= r_status_next;
        out_valid_reg <= out_valid_next;
        out_entry_reg <= out_entry_next;
        status_reg <= status_next;
        occ_reg <= occ_next;
    end

endmodule

### rtl/sipq_checker.sv
`timescale 1ns / 1ps

`include "sorted_insert_priority_queue_top_macros.svh"

module sipq_checker #(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               cmd,
    input logic [sipq_pkg::TIME_W-1:0]        item_time,
    input logic [sipq_pkg::INFO_W-1:0]        item_info,
    input logic                               res_valid,
    input logic                               res_stall,
    input logic                               out_valid,
    input logic [sipq_pkg::TIME_W-1:0]        out_time,
    input logic [sipq_pkg::INFO_W-1:0]        out_info,
    input logic [sipq_pkg::STATUS_W-1:0]      status,
    input logic [sipq_pkg::OCC_W-1:0]         occupancy
);

    // one command in flight: the block is busy right after a transaction
    `SIPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a dequeued entry always comes with an OK status
    `SIPQ_ASSERT_NOW(a_entry_means_done, res_valid && out_valid,
        status == sipq_pkg::STATUS_OK)

    // no entry: time and info read as zero
    `SIPQ_ASSERT_NOW(a_zero_fields, res_valid && !out_valid,
        out_time == '0 && out_info == '0)

    `SIPQ_ASSERT_NOW(a_occ_bound, res_valid, (DEPTH > 31) || (occupancy <= DEPTH))

    `SIPQ_ASSERT_NEXT(a_result_held, res_valid && res_stall,
        res_valid && $stable(out_time) && $stable(occupancy))

endmodule

bind sorted_insert_priority_queue_top sipq_checker #(.DEPTH(DEPTH)) u_sipq_checker (.*);

### tb/sorted_insert_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module sorted_insert_priority_queue_top_tb;

    localparam int QDEPTH = sipq_pkg::DEPTH_DEFAULT;
    localparam int NUM_RANDOM_CMDS = 800;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic                        op;
        logic [sipq_pkg::TIME_W-1:0] time_key;
        logic [sipq_pkg::INFO_W-1:0] info;
    } queue_cmd_t;

    typedef struct packed {
        logic                          out_valid;
        logic [sipq_pkg::TIME_W-1:0]   out_time;
        logic [sipq_pkg::INFO_W-1:0]   out_info;
        logic [sipq_pkg::STATUS_W-1:0] status;
        logic [sipq_pkg::OCC_W-1:0]    occupancy;
    } queue_reply_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          cmd = sipq_pkg::CMD_ENQ;
    logic [sipq_pkg::TIME_W-1:0]   item_time = '0;
    logic [sipq_pkg::INFO_W-1:0]   item_info = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    logic                          out_valid;
    logic [sipq_pkg::TIME_W-1:0]   out_time;
    logic [sipq_pkg::INFO_W-1:0]   out_info;
    logic [sipq_pkg::STATUS_W-1:0] status;
    logic [sipq_pkg::OCC_W-1:0]    occupancy;

    queue_cmd_t   pending_cmds[$];
    queue_reply_t expected_replies[$];

    // shadow copy of the sorted circular buffer
    logic [sipq_pkg::TIME_W-1:0] slot_time[QDEPTH];
    logic [sipq_pkg::INFO_W-1:0] slot_info[QDEPTH];
    int unsigned                 q_head = 0;
    int unsigned                 q_tail = 0;
    int unsigned                 q_count = 0;

    int  mismatches = 0;
    int  cycle_count = 0;
    int  cmds_accepted = 0;
    bit  in_taken = 1'b0;
    bit  res_taken = 1'b0;
    bit  hold_on = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;

    sorted_insert_priority_queue_top #(
        .DEPTH(QDEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .item_time(item_time),
        .item_info(item_info),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .out_valid(out_valid),
        .out_time(out_time),
        .out_info(out_info),
        .status(status),
        .occupancy(occupancy)
    );

    always #5 clk = ~clk;

    // enqueue walks the new entry toward the head past strictly larger times
    function automatic queue_reply_t apply_queue_cmd(logic op,
                                                     logic [sipq_pkg::TIME_W-1:0] key,
                                                     logic [sipq_pkg::INFO_W-1:0] info);
        queue_reply_t                reply;
        int unsigned                 pos;
        int unsigned                 prv;
        logic [sipq_pkg::TIME_W-1:0] swap_time;
        logic [sipq_pkg::INFO_W-1:0] swap_info;
        reply = '0;
        reply.status = sipq_pkg::STATUS_OK;
        if (op == sipq_pkg::CMD_ENQ)
        begin
            if (q_count >= QDEPTH)
            begin
                reply.status = sipq_pkg::STATUS_FULL;
            end
            else
            begin
                pos = q_tail;
                slot_time[pos] = key;
                slot_info[pos] = info;
                while (pos != q_head)
                begin
                    prv = (pos == 0) ? QDEPTH - 1 : pos - 1;
                    if (!(slot_time[pos] < slot_time[prv]))
                        break;
                    swap_time = slot_time[pos];
                    slot_time[pos] = slot_time[prv];
                    slot_time[prv] = swap_time;
                    swap_info = slot_info[pos];
                    slot_info[pos] = slot_info[prv];
                    slot_info[prv] = swap_info;
                    pos = prv;
                end
                q_tail = (q_tail + 1 == QDEPTH) ? 0 : q_tail + 1;
                q_count++;
            end
        end
        else
        begin
            if (q_count == 0)
            begin
                reply.status = sipq_pkg::STATUS_EMPTY;
            end
            else
            begin
                reply.out_valid = 1'b1;
                reply.out_time = slot_time[q_head];
                reply.out_info = slot_info[q_head];
                q_head = (q_head + 1 == QDEPTH) ? 0 : q_head + 1;
                q_count--;
            end
        end
        reply.occupancy = q_count[sipq_pkg::OCC_W-1:0];
        return reply;
    endfunction

    // calm windows give stretches with no idling on either side
    function automatic int draw_gap();
        if ((cycle_count % 3000) < 500)
            return 0;
        return int'($urandom_range(0, 8));
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic next_valid;
        queue_cmd_t c;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_taken)
            begin
                in_taken = 1'b0;
                next_valid = 1'b0;
                send_gap = draw_gap();
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_cmds.size() != 0)
                begin
                    c = pending_cmds.pop_front();
                    cmd <= c.op;
                    item_time <= c.time_key;
                    item_info <= c.info;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(negedge clk)
    begin
        int hold_left;
        int holds_done;
        if (hold_left > 0)
            hold_left--;
        else if (holds_done < 2 && cmds_accepted >= (holds_done + 1) * 250)
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        hold_on <= (hold_left > 0);
    end

    always @(negedge clk)
    begin
        if (res_taken)
        begin
            res_taken = 1'b0;
            recv_gap = draw_gap();
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
        end
        res_stall <= hold_on || (recv_gap > 0);
    end

    // monitor: check replies first, then predict for the accepted transaction
    always @(posedge clk)
    begin
        queue_reply_t got;
        queue_reply_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                res_taken = 1'b1;
                got = '{out_valid, out_time, out_info, status, occupancy};
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected reply: valid=%0d time=%h info=%h status=%0d occ=%0d",
                                 got.out_valid, got.out_time, got.out_info, got.status,
                                 got.occupancy);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"reply mismatch: expected valid=%0d time=%h info=%h ",
                                      "status=%0d occ=%0d, got valid=%0d time=%h info=%h ",
                                      "status=%0d occ=%0d"},
                                     want.out_valid, want.out_time, want.out_info,
                                     want.status, want.occupancy, got.out_valid,
                                     got.out_time, got.out_info, got.status, got.occupancy);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                cmds_accepted++;
                expected_replies.push_back(apply_queue_cmd(cmd, item_time, item_info));
            end
        end
    end

    initial
    begin
        queue_cmd_t c;
        int mode;
        int run_len;
        int enq_pct;
        int n;
        for (int i = 0; i < QDEPTH; i++)
        begin
            slot_time[i] = '0;
            slot_info[i] = '0;
        end

        // dequeue on empty, fill with extreme and repeated keys, enqueue on full, dequeue six
        pending_cmds.push_back('{sipq_pkg::CMD_DEQ, 16'h0000, 8'h00});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'hFFFF, 8'hFF});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h0000, 8'h00});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h8000, 8'hAA});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h0000, 8'h55});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'hFFFF, 8'h01});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h1234, 8'h80});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h0001, 8'h7F});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h7FFF, 8'h02});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h00FF, 8'hFE});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'hFF00, 8'h33});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h5555, 8'hCC});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'hAAAA, 8'h44});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h0002, 8'hBB});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h8000, 8'h11});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'hFFFE, 8'h22});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h0003, 8'hDD});
        pending_cmds.push_back('{sipq_pkg::CMD_ENQ, 16'h0000, 8'hEE});
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back('{sipq_pkg::CMD_DEQ, 16'hFFFF, 8'hFF});

        // random runs biased to fill, drain, balance, or crowd onto few keys
        n = 0;
        while (n < NUM_RANDOM_CMDS)
        begin
            mode = $urandom_range(0, 3);
            run_len = $urandom_range(10, 50);
            case (mode)
                0: enq_pct = 85;
                1: enq_pct = 15;
                2: enq_pct = 50;
                default: enq_pct = 60;
            endcase
            for (int k = 0; k < run_len && n < NUM_RANDOM_CMDS; k++)
            begin
                c.op = ($urandom_range(0, 99) < enq_pct) ? sipq_pkg::CMD_ENQ : sipq_pkg::CMD_DEQ;
                if (mode == 3 || $urandom_range(0, 3) == 0)
                    c.time_key = 16'($urandom_range(0, 7));
                else if ($urandom_range(0, 9) == 0)
                    c.time_key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    c.time_key = 16'($urandom_range(0, 16'hFFFF));
                c.info = 8'($urandom_range(0, 8'hFF));
                pending_cmds.push_back(c);
                n++;
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_replies.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sipq_pkg.sv
rtl/sipq_ram.sv
rtl/sorted_insert_priority_queue_top.sv
rtl/sipq_checker.sv
tb/sorted_insert_priority_queue_top_tb.sv
